// ===== sv/box_nms_filter_top_assert.svh =====
// Assertion macros for the box NMS filter top level.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BOX_NMS_FILTER_TOP_ASSERT_SVH
`define BOX_NMS_FILTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bnf_pkg.sv =====
// Shared types and constants for the box NMS filter.
// No dependencies.
`default_nettype none
package bnf_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int IDX_W   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
  localparam int SCORE_W = 16;
  localparam int COORD_W = 14;
  localparam int KEPT_W  = 6;
  localparam int THR_W   = 16;

  // stages in the overlap test unit; the ring is the cells plus these stages
  localparam int PIPE_DEPTH = 4;
  localparam int RING_LEN   = MAX_CANDIDATES + PIPE_DEPTH;
  localparam int PASS_W     = $clog2(RING_LEN);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR  = 2'd1;

  localparam logic [THR_W-1:0] CONF_THR_RESET = 16'd16384;
  localparam logic [THR_W-1:0] IOU_THR_RESET  = 16'd29491;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } entry_t;

  typedef struct packed {
    logic load_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/box_nms_filter_top.sv =====
// Box NMS filter top level: candidate ring of cells, overlap unit, control.
// Depends on bnf_pkg, bnf_cell, bnf_iou and box_nms_filter_top_assert.svh.
//
// Boxes are taken one per cycle while busy is low; a box at or above the
// confidence threshold is inserted, while room remains, into a row of 64
// cells kept sorted by score. After the box marked last_box, busy rises
// and the cells, joined with the 4 stages of the overlap unit, rotate as
// a 68-slot ring: each full turn takes the best remaining box as kept
// and removes the boxes it overlaps too much. An empty set answers at
// once. Results appear for one cycle on out_valid and cannot be
// stalled; the final one carries out_last_result.
`default_nettype none
module box_nms_filter_top (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [15:0]                     in_score,
  input  wire  [13:0]                     in_center_x,
  input  wire  [13:0]                     in_center_y,
  input  wire  [13:0]                     in_box_width,
  input  wire  [13:0]                     in_box_height,
  input  wire                             in_last_box,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [bnf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [15:0]                     cfg_data,
  output logic                            out_valid,
  output logic [5:0]                      out_kept_index,
  output logic [15:0]                     out_kept_score,
  output logic [13:0]                     out_kept_x,
  output logic [13:0]                     out_kept_y,
  output logic [13:0]                     out_kept_w,
  output logic [13:0]                     out_kept_h,
  output logic                            out_none_found,
  output logic                            out_overflowed,
  output logic                            out_last_result
);

  localparam int N = bnf_pkg::MAX_CANDIDATES;
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [bnf_pkg::PASS_W-1:0] PASS_END = bnf_pkg::PASS_W'(bnf_pkg::RING_LEN - 1);

  logic state_r, state_nxt;
  logic [bnf_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [bnf_pkg::PASS_W-1:0] pass_r, pass_nxt;
  logic                       found_r, found_nxt, have_r, have_nxt;
  bnf_pkg::entry_t            ref_r, ref_nxt;
  logic [15:0]                conf_thr_r, iou_thr_r;

  bnf_pkg::entry_t   new_e, pipe_in, pipe_out;
  bnf_pkg::entry_t   cell_q [N];
  bnf_pkg::entry_t   prev_e [N];
  bnf_pkg::entry_t   next_e [N];
  logic [N-1:0]      gt, prev_g;
  bnf_pkg::cell_ctrl_t ctrl;

  logic accept, pass_thr, insert, capture;

  assign busy      = (state_r == ST_RUN);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign pass_thr  = (in_score >= conf_thr_r);
  assign insert    = accept && pass_thr && (count_r < bnf_pkg::CNT_W'(N));
  assign capture   = busy && cell_q[0].valid && !found_r;

  always_comb begin
    new_e.valid = 1'b1;
    new_e.idx   = bnf_pkg::IDX_W'(count_r);
    new_e.score = in_score;
    new_e.cx    = in_center_x;
    new_e.cy    = in_center_y;
    new_e.w     = in_box_width;
    new_e.h     = in_box_height;
    ctrl.load_en  = insert;
    ctrl.shift_en = busy;
    pipe_in       = cell_q[0];
    // the reference box leaves the ring instead of entering the test;
    // keep the test empty while loading
    if (capture || !busy) begin
      pipe_in.valid = 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_e[i] = new_e;
      assign prev_g[i] = 1'b0;
    end else begin : g_body
      assign prev_e[i] = cell_q[i-1];
      assign prev_g[i] = gt[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_e[i] = pipe_out;
    end else begin : g_mid
      assign next_e[i] = cell_q[i+1];
    end
    bnf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_entry (new_e),
      .prev_entry(prev_e[i]),
      .next_entry(next_e[i]),
      .prev_gt   (prev_g[i]),
      .entry_q   (cell_q[i]),
      .gt        (gt[i])
    );
  end

  bnf_iou u_iou (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_entry (pipe_in),
    .ref_entry(ref_r),
    .iou_thr  (iou_thr_r),
    .out_entry(pipe_out)
  );

  // result register
  logic        ov_nxt, on_nxt, ol_nxt, oo_nxt;
  bnf_pkg::entry_t oe_nxt;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    pass_nxt  = pass_r;
    found_nxt = found_r;
    have_nxt  = have_r;
    ref_nxt   = ref_r;
    ov_nxt    = 1'b0;
    on_nxt    = 1'b0;
    ol_nxt    = 1'b0;
    oo_nxt    = ovf_r;
    oe_nxt    = ref_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (insert) begin
            count_nxt = count_r + 1'b1;
          end else if (pass_thr) begin
            ovf_nxt = 1'b1;
          end
          if (in_last_box) begin
            if (count_nxt == '0) begin
              ov_nxt    = 1'b1;
              on_nxt    = 1'b1;
              ol_nxt    = 1'b1;
              oo_nxt    = ovf_nxt;
              oe_nxt    = '0;
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end else begin
              state_nxt = ST_RUN;
              pass_nxt  = '0;
              found_nxt = 1'b0;
              have_nxt  = 1'b0;
            end
          end
        end
      end
      ST_RUN: begin
        pass_nxt = pass_r + 1'b1;
        if (capture) begin
          // hand out the previous kept box, hold the new one
          ov_nxt    = have_r;
          ref_nxt   = cell_q[0];
          found_nxt = 1'b1;
          have_nxt  = 1'b1;
        end
        if (pass_r == PASS_END) begin
          pass_nxt  = '0;
          found_nxt = 1'b0;
          if (!found_r && !capture) begin
            ov_nxt    = 1'b1;
            ol_nxt    = 1'b1;
            state_nxt = ST_LOAD;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            have_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      pass_r     <= '0;
      found_r    <= 1'b0;
      have_r     <= 1'b0;
      out_valid  <= 1'b0;
      conf_thr_r <= bnf_pkg::CONF_THR_RESET;
      iou_thr_r  <= bnf_pkg::IOU_THR_RESET;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      pass_r    <= pass_nxt;
      found_r   <= found_nxt;
      have_r    <= have_nxt;
      out_valid <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bnf_pkg::CFG_CONF_THR: conf_thr_r <= cfg_data;
          bnf_pkg::CFG_IOU_THR:  iou_thr_r  <= cfg_data;
          default: ;
        endcase
      end
    end
    ref_r           <= ref_nxt;
    out_kept_index  <= bnf_pkg::KEPT_W'(oe_nxt.idx);
    out_kept_score  <= oe_nxt.score;
    out_kept_x      <= oe_nxt.cx;
    out_kept_y      <= oe_nxt.cy;
    out_kept_w      <= oe_nxt.w;
    out_kept_h      <= oe_nxt.h;
    out_none_found  <= on_nxt;
    out_overflowed  <= oo_nxt;
    out_last_result <= ol_nxt;
  end

`include "box_nms_filter_top_assert.svh"

  `BNF_ASSERT_NOW(a_last_idle, out_valid && out_last_result, !busy, "last result while busy")
  `BNF_ASSERT_NOW(a_none_last, out_valid && out_none_found, out_last_result, "none_found not last")
  `BNF_ASSERT_NEXT(a_last_box, start && !busy && in_last_box, busy || out_valid, "last box lost")

endmodule
`default_nettype wire

// ===== sv/bnf_cell.sv =====
// One cell of the candidate ring: sorted insert while loading, rotate while suppressing.
// Depends on bnf_pkg.
`default_nettype none
module bnf_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bnf_pkg::cell_ctrl_t  ctrl,
  input  bnf_pkg::entry_t      new_entry,
  input  bnf_pkg::entry_t      prev_entry,
  input  bnf_pkg::entry_t      next_entry,
  input  wire                  prev_gt,
  output bnf_pkg::entry_t      entry_q,
  output logic                 gt
);

  bnf_pkg::entry_t entry_r, entry_nxt;

  // new box ranks ahead of this one; ties stay behind the earlier box
  assign gt = !entry_r.valid || (new_entry.score > entry_r.score);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift_en) begin
      entry_nxt = next_entry;
    end else if (ctrl.load_en && gt) begin
      entry_nxt = prev_gt ? prev_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.idx   <= entry_nxt.idx;
    entry_r.score <= entry_nxt.score;
    entry_r.cx    <= entry_nxt.cx;
    entry_r.cy    <= entry_nxt.cy;
    entry_r.w     <= entry_nxt.w;
    entry_r.h     <= entry_nxt.h;
  end

  assign entry_q = entry_r;

endmodule
`default_nettype wire

// ===== sv/bnf_iou.sv =====
// Pipelined overlap test of a streaming box against the reference box.
// Drops the box when inter * 65536 > thr * union and union > 0. Depends on bnf_pkg.
`default_nettype none
module bnf_iou (
  input  wire                          clk,
  input  wire                          rst_n,
  input  bnf_pkg::entry_t              in_entry,
  input  bnf_pkg::entry_t              ref_entry,
  input  wire [bnf_pkg::THR_W-1:0]     iou_thr,
  output bnf_pkg::entry_t              out_entry
);

  localparam int EW = bnf_pkg::COORD_W + 3;  // signed edge, 2*c +/- size

  // stage 0: edges and intersection extents
  logic signed [EW-1:0] el, er, et, ed, hl, hr, ht, hd, xl, xr, yt, yd;
  logic signed [EW:0]   dx, dy;
  logic [15:0]          iw, ih;

  always_comb begin
    el = signed'({2'b00, in_entry.cx, 1'b0}) - signed'({3'b000, in_entry.w});
    er = signed'({2'b00, in_entry.cx, 1'b0}) + signed'({3'b000, in_entry.w});
    et = signed'({2'b00, in_entry.cy, 1'b0}) - signed'({3'b000, in_entry.h});
    ed = signed'({2'b00, in_entry.cy, 1'b0}) + signed'({3'b000, in_entry.h});
    hl = signed'({2'b00, ref_entry.cx, 1'b0}) - signed'({3'b000, ref_entry.w});
    hr = signed'({2'b00, ref_entry.cx, 1'b0}) + signed'({3'b000, ref_entry.w});
    ht = signed'({2'b00, ref_entry.cy, 1'b0}) - signed'({3'b000, ref_entry.h});
    hd = signed'({2'b00, ref_entry.cy, 1'b0}) + signed'({3'b000, ref_entry.h});
    xl = (el > hl) ? el : hl;
    xr = (er < hr) ? er : hr;
    yt = (et > ht) ? et : ht;
    yd = (ed < hd) ? ed : hd;
    dx = {xr[EW-1], xr} - {xl[EW-1], xl};
    dy = {yd[EW-1], yd} - {yt[EW-1], yt};
    iw = (dx > 0) ? dx[15:0] : 16'd0;
    ih = (dy > 0) ? dy[15:0] : 16'd0;
  end

  bnf_pkg::entry_t e1_r, e2_r, e3_r, e4_r;
  logic [15:0] iw1_r, ih1_r;
  logic [14:0] ew1_r, eh1_r;
  logic [31:0] inter2_r, inter3_r, inter4_r;
  logic [29:0] area2_r, area_ref_r;
  logic [31:0] uni3_r;
  logic        pos4_r;
  logic [31:0] plo4_r, phi4_r;

  logic [31:0] uni;
  logic [47:0] lhs, rhs;

  assign uni = {2'b00, area_ref_r} + {2'b00, area2_r} - inter2_r;
  assign lhs = {inter4_r, 16'd0};
  assign rhs = {phi4_r, 16'd0} + {16'd0, plo4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r.valid <= 1'b0;
      e2_r.valid <= 1'b0;
      e3_r.valid <= 1'b0;
      e4_r.valid <= 1'b0;
    end else begin
      e1_r.valid <= in_entry.valid;
      e2_r.valid <= e1_r.valid;
      e3_r.valid <= e2_r.valid;
      e4_r.valid <= e3_r.valid;
    end
    {e1_r.idx, e1_r.score, e1_r.cx, e1_r.cy, e1_r.w, e1_r.h} <=
      {in_entry.idx, in_entry.score, in_entry.cx, in_entry.cy, in_entry.w, in_entry.h};
    {e2_r.idx, e2_r.score, e2_r.cx, e2_r.cy, e2_r.w, e2_r.h} <=
      {e1_r.idx, e1_r.score, e1_r.cx, e1_r.cy, e1_r.w, e1_r.h};
    {e3_r.idx, e3_r.score, e3_r.cx, e3_r.cy, e3_r.w, e3_r.h} <=
      {e2_r.idx, e2_r.score, e2_r.cx, e2_r.cy, e2_r.w, e2_r.h};
    {e4_r.idx, e4_r.score, e4_r.cx, e4_r.cy, e4_r.w, e4_r.h} <=
      {e3_r.idx, e3_r.score, e3_r.cx, e3_r.cy, e3_r.w, e3_r.h};
    // stage 1
    iw1_r <= iw;
    ih1_r <= ih;
    ew1_r <= {in_entry.w, 1'b0};
    eh1_r <= {in_entry.h, 1'b0};
    // stage 2
    inter2_r   <= iw1_r * ih1_r;
    area2_r    <= ew1_r * eh1_r;
    area_ref_r <= {ref_entry.w, 1'b0} * {ref_entry.h, 1'b0};
    // stage 3
    inter3_r <= inter2_r;
    uni3_r   <= uni;
    // stage 4: threshold times union in two halves
    inter4_r <= inter3_r;
    pos4_r   <= (uni3_r != 32'd0);
    plo4_r   <= iou_thr * uni3_r[15:0];
    phi4_r   <= iou_thr * uni3_r[31:16];
  end

  always_comb begin
    out_entry       = e4_r;
    out_entry.valid = e4_r.valid && !(pos4_r && (lhs > rhs));
  end

endmodule
`default_nettype wire
